// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== hdl/kwmv_pkg.sv =====
// Package: widths and beat types for the keyed weighted mean/variance core
`timescale 1ns / 1ps
package kwmv_pkg;
   localparam int KEY_W    = 10;
   localparam int WEIGHT_W = 16;
   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = 24;
   localparam int SQ_W     = 40;
   localparam int MEAN_W   = 32;
   localparam int SPREAD_W = 47;

   typedef struct packed {
      logic [KEY_W-1:0]           key_slot;
      logic [WEIGHT_W-1:0]        weight;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]         weight_total;
      logic [SQ_W-1:0]          weight_square_total;
      logic signed [MEAN_W-1:0] running_mean;
      logic [SPREAD_W-1:0]      spread_total;
      logic                     first_sample;
      logic                     divide_fault;
   } rsp_type;

   // serial multiplier and divider control/status
   typedef struct packed {
      logic start;
   } mul_ctl_type;
   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;
endpackage

// ===== hdl/kwmv_if.sv =====
// Valid/ready channel interfaces
`timescale 1ns / 1ps
interface kwmv_req_if;
   logic              valid;
   logic              ready;
   kwmv_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface kwmv_rsp_if;
   logic              valid;
   logic              ready;
   kwmv_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/keyed_weighted_mean_variance_core.sv =====
// Steps for a revisited key, in order: table read, serial w*w, w*|d1|,
// divide by the new sum, spread product, writeback.
// First beat of a key or a zero-sum beat: table read, w*w, writeback.
// Concurrency: one beat in flight; no beat is accepted until writeback, which waits on any result stall.
// Reset: synchronous, active high; after reset a clearing pass over all KEY_SLOTS
// slots zeroes the seen flags, during which no beat is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keyed_weighted_mean_variance_core #(
   parameter int KEY_SLOTS = 1024
) (
   input logic      clock,
   input logic      reset,
   kwmv_req_if.sink   req,
   kwmv_rsp_if.source rsp
);
   localparam int AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int CW = $clog2(KEY_SLOTS + 1);

   typedef enum logic [10:0] {
      S_CLR  = 11'b00000000001,
      S_IDLE = 11'b00000000010,
      S_RD   = 11'b00000000100,
      S_DEC  = 11'b00000001000,
      S_SQ   = 11'b00000010000,
      S_M1   = 11'b00000100000,
      S_DIV  = 11'b00001000000,
      S_M2   = 11'b00010000000,
      S_M3   = 11'b00100000000,
      S_WB   = 11'b01000000000,
      S_OUT  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic                      seen_mem [KEY_SLOTS];
   logic [kwmv_pkg::SUM_W-1:0]    sum_mem [KEY_SLOTS];
   logic [kwmv_pkg::SQ_W-1:0]     sq_mem [KEY_SLOTS];
   logic [kwmv_pkg::MEAN_W-1:0]   mean_mem [KEY_SLOTS];
   logic [kwmv_pkg::SPREAD_W-1:0] spr_mem [KEY_SLOTS];

   logic [CW-1:0] clr_ff, clr_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [15:0]   w_ff, w_in;
   logic signed [32:0] x_ff, x_in;
   logic          seen_rd;
   logic [23:0]   sum_rd;
   logic [39:0]   sq_rd;
   logic [31:0]   mean_rd;
   logic [46:0]   spr_rd;
   logic [23:0]   nsum_ff, nsum_in;
   logic [39:0]   nsq_ff, nsq_in;
   logic [31:0]   nmean_ff, nmean_in;
   logic [46:0]   nspr_ff, nspr_in;
   logic          first_ff, first_in, fault_ff, fault_in;
   logic          d1neg_ff, d1neg_in;
   logic [32:0]   d1mag_ff, d1mag_in;
   logic [48:0]   wd1_ff, wd1_in;
   kwmv_pkg::rsp_type rsp_ff, rsp_in;
   logic          rv_ff, rv_in;

   kwmv_pkg::mul_ctl_type mctl, dctl;
   kwmv_pkg::mul_sts_type msts, dsts;
   logic [48:0] ma;
   logic [33:0] mb;
   logic [82:0] mp;
   logic [48:0] quo;

   logic signed [33:0] d1, d2;
   logic signed [33:0] nmean_w;
   logic [24:0] sum_add;
   logic [40:0] sq_add;
   logic [47:0] spr_add;
   logic [50:0] inc;

   kwmv_mul #(.A_W(49), .B_W(34)) u_mul (
      .clock, .reset, .ctl(mctl), .a(ma), .b(mb), .sts(msts), .p(mp));
   kwmv_div #(.N_W(49), .D_W(24)) u_div (
      .clock, .reset, .ctl(dctl), .num(wd1_in), .den(nsum_ff), .sts(dsts),
      .quo(quo));

   always_ff @(posedge clock) begin
      seen_rd <= seen_mem[slot_ff];
      sum_rd  <= sum_mem[slot_ff];
      sq_rd   <= sq_mem[slot_ff];
      mean_rd <= mean_mem[slot_ff];
      spr_rd  <= spr_mem[slot_ff];
      if (state_ff == S_CLR) seen_mem[clr_ff[AW-1:0]] <= 1'b0;
      else if (state_ff == S_WB) begin
         seen_mem[slot_ff] <= 1'b1;
         sum_mem[slot_ff]  <= nsum_ff;
         sq_mem[slot_ff]   <= nsq_ff;
         mean_mem[slot_ff] <= nmean_ff;
         spr_mem[slot_ff]  <= nspr_ff;
      end
   end

   assign d1      = 34'(x_ff) - 34'($signed(mean_rd));
   assign nmean_w = 34'($signed(mean_rd)) + (d1neg_ff ? -34'(quo) : 34'(quo));
   assign d2      = 34'(x_ff) - nmean_w;
   assign sum_add = {1'b0, sum_rd} + 25'(w_ff);
   assign sq_add  = {1'b0, sq_rd} + 41'(mp[31:0]);
   assign inc     = mp[82:32];
   assign spr_add = {1'b0, spr_rd} +
                    ((inc > 51'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : 48'(inc));

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      slot_in  = slot_ff;
      w_in     = w_ff;
      x_in     = x_ff;
      nsum_in  = nsum_ff;
      nsq_in   = nsq_ff;
      nmean_in = nmean_ff;
      nspr_in  = nspr_ff;
      first_in = first_ff;
      fault_in = fault_ff;
      d1neg_in = d1neg_ff;
      d1mag_in = d1mag_ff;
      wd1_in   = wd1_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff;
      mctl.start = 1'b0;
      dctl.start = 1'b0;
      ma = 49'(w_ff);
      mb = 34'(w_ff);
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(KEY_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               slot_in  = AW'(req.data.key_slot % KEY_SLOTS);
               w_in     = req.data.weight;
               x_in     = 33'(req.data.sample);
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_DEC;
         S_DEC: begin
            mctl.start = 1'b1;
            first_in   = !seen_rd;
            fault_in   = 1'b0;
            d1neg_in   = d1[33];
            d1mag_in   = d1[33] ? 33'(-d1) : 33'(d1);
            nsum_in    = (!seen_rd) ? 24'(w_ff) :
                         (sum_add[24] ? 24'hFFFFFF : sum_add[23:0]);
            state_in   = S_SQ;
         end
         S_SQ: begin
            if (msts.done) begin
               if (first_ff) begin
                  nsq_in   = 40'(mp[31:0]);
                  nmean_in = x_ff[31:0];
                  nspr_in  = '0;
                  state_in = S_WB;
               end else begin
                  nsq_in = sq_add[40] ? 40'hFFFFFFFFFF : sq_add[39:0];
                  if (nsum_ff == '0) begin
                     fault_in = 1'b1;
                     nmean_in = mean_rd;
                     nspr_in  = spr_rd;
                     state_in = S_WB;
                  end else begin
                     mctl.start = 1'b1;
                     mb = 34'(d1mag_ff);
                     state_in = S_M1;
                  end
               end
            end
         end
         S_M1: begin
            mb = 34'(d1mag_ff);
            if (msts.done) begin
               wd1_in     = mp[48:0];
               state_in   = S_DIV;
               dctl.start = 1'b1;
            end
         end
         S_DIV: begin
            if (dsts.done) begin
               nmean_in   = nmean_w[31:0];
               mctl.start = 1'b1;
               ma = wd1_ff;
               mb = d2[33] ? 34'(-d2) : 34'(d2);
               state_in   = S_M2;
            end
         end
         S_M2: begin
            ma = wd1_ff;
            if (msts.done) begin
               nspr_in  = spr_add[47] ? 47'h7FFFFFFFFFFF : spr_add[46:0];
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (!rv_ff || rsp.ready) begin
               rsp_in.weight_total        = nsum_ff;
               rsp_in.weight_square_total = nsq_ff;
               rsp_in.running_mean        = nmean_ff;
               rsp_in.spread_total        = nspr_ff;
               rsp_in.first_sample        = first_ff;
               rsp_in.divide_fault        = fault_ff;
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_M3, S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      w_ff     <= w_in;
      x_ff     <= x_in;
      nsum_ff  <= nsum_in;
      nsq_ff   <= nsq_in;
      nmean_ff <= nmean_in;
      nspr_ff  <= nspr_in;
      first_ff <= first_in;
      fault_ff <= fault_in;
      d1neg_ff <= d1neg_in;
      d1mag_ff <= d1mag_in;
      wd1_ff   <= wd1_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.data  = rsp_ff;

   `ASSERT_CLK(a_no_accept_busy, clock, reset, req.valid && req.ready |=> state_ff == S_RD)
   `ASSERT_CLK(a_first_no_fault, clock, reset, rsp.valid |-> !(rsp.data.first_sample && rsp.data.divide_fault))
   `ASSERT_CLK(a_units_exclusive, clock, reset, !(msts.busy && dsts.busy))
   `ASSERT_NORST(a_reset_clear, clock, reset |=> state_ff == S_CLR && !rv_ff)
endmodule

// ===== hdl/kwmv_mul.sv =====
// Bit-serial unsigned multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
module kwmv_mul #(
   parameter int A_W = 49,
   parameter int B_W = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kwmv_pkg::mul_ctl_type ctl,
   input  logic [A_W-1:0]        a,
   input  logic [B_W-1:0]        b,
   output kwmv_pkg::mul_sts_type sts,
   output logic [A_W+B_W-1:0]    p
);
   localparam int CNT_W = $clog2(B_W + 1);
   logic [A_W+B_W-1:0] acc_ff, acc_in;
   logic [A_W+B_W-1:0] mc_ff, mc_in;
   logic [B_W-1:0]     mp_ff, mp_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         acc_in  = '0;
         mc_in   = {{B_W{1'b0}}, a};
         mp_in   = b;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in  = mc_ff << 1;
         mp_in  = mp_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign p        = acc_ff;
endmodule

// ===== hdl/kwmv_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned
`timescale 1ns / 1ps
module kwmv_div #(
   parameter int N_W = 49,
   parameter int D_W = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kwmv_pkg::mul_ctl_type ctl,
   input  logic [N_W-1:0]        num,
   input  logic [D_W-1:0]        den,
   output kwmv_pkg::mul_sts_type sts,
   output logic [N_W-1:0]        quo
);
   localparam int CNT_W = $clog2(N_W + 1);
   logic [N_W-1:0]   q_ff, q_in;
   logic [D_W:0]     r_ff, r_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [D_W:0]     trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[D_W-1:0], q_ff[N_W-1]};
      if (ctl.start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = CNT_W'(N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[N_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = q_ff;
endmodule
